// ----- rtl/bdt_pkg.sv -----
// Shared types and constants of the boost deadline timer.
package bdt_pkg;

	localparam int unsigned MAX_MINUTES = 480;
	localparam int unsigned MS_PER_MIN  = 60000;
	localparam int unsigned ROUND_UP_MS = 999;
	localparam int unsigned MS_PER_S    = 1000;

	localparam int REM_W = 15;
	localparam logic [REM_W-1:0] REM_MAX = {REM_W{1'b1}};

	localparam logic signed [15:0] FLOW_MIN_RST = 16'sd200;
	localparam logic signed [15:0] FLOW_MAX_RST = 16'sd800;

	// beyond this many milliseconds the rounded-up seconds no longer fit
	localparam longint unsigned REM_SAT_MS = longint'(REM_MAX) * MS_PER_S;
	localparam int SECS_IN_W = $clog2(REM_SAT_MS + ROUND_UP_MS + 1);
	localparam int RECIP_SHIFT = SECS_IN_W + $clog2(MS_PER_S);
	localparam longint unsigned RECIP_MUL =
		((64'd1 << RECIP_SHIFT) + MS_PER_S - 1) / MS_PER_S;
	localparam int RECIP_W = $clog2(RECIP_MUL + 1);

	typedef enum logic [1:0] {
		KIND_START  = 2'd0,
		KIND_CANCEL = 2'd1,
		KIND_TICK   = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		ST_OK      = 3'd0,
		ST_REMOTE  = 3'd1,
		ST_SEASON  = 3'd2,
		ST_MINUTES = 3'd3,
		ST_RANGE   = 3'd4
	} status_t;

	typedef enum logic {
		CFG_FLOW_MIN = 1'b0,
		CFG_FLOW_MAX = 1'b1
	} cfg_idx_t;

	typedef struct packed {
		kind_t              kind;
		logic [31:0]        now_ms;
		logic signed [15:0] setpoint_tenths;
		logic [15:0]        duration_min;
		logic               remote_owned;
		logic               season_on;
	} item_t;

	typedef struct packed {
		logic               running;
		logic signed [15:0] held_setpoint;
		logic [31:0]        deadline_ms;
	} boost_t;

	typedef struct packed {
		status_t     status;
		logic        counting;
		logic [31:0] left_ms;
	} step_t;

endpackage

// ----- rtl/bdt_eval.sv -----
// Start checks, state update and time left for one transaction.
module bdt_eval (
	input  bdt_pkg::item_t      item,
	input  bdt_pkg::boost_t     cur,
	input  logic signed [15:0]  flow_min,
	input  logic signed [15:0]  flow_max,
	output bdt_pkg::boost_t     nxt,
	output bdt_pkg::step_t      step
);
	import bdt_pkg::*;

	logic [31:0] span_ms;
	logic [31:0] neg_span;
	logic [31:0] since_dl;
	logic [31:0] left_ms;
	logic        reached;
	logic        minutes_bad;
	logic        setpoint_bad;
	logic        not_reached;

	assign span_ms      = 32'(item.duration_min) * 32'(MS_PER_MIN);
	assign neg_span     = 32'd0 - span_ms;
	assign since_dl     = item.now_ms - cur.deadline_ms;
	assign left_ms      = cur.deadline_ms - item.now_ms;
	assign reached      = ~since_dl[31];
	assign minutes_bad  = (item.duration_min == 16'd0) ||
		(item.duration_min > 16'(MAX_MINUTES));
	assign setpoint_bad = (item.setpoint_tenths < flow_min) ||
		(item.setpoint_tenths > flow_max);

	always_comb begin
		nxt          = cur;
		step.status  = ST_OK;
		step.left_ms = left_ms;
		not_reached  = since_dl[31];
		case (item.kind)
			KIND_START: begin
				if (item.remote_owned) begin
					step.status = ST_REMOTE;
				end else if (!item.season_on) begin
					step.status = ST_SEASON;
				end else if (minutes_bad) begin
					step.status = ST_MINUTES;
				end else if (setpoint_bad) begin
					step.status = ST_RANGE;
				end else begin
					nxt.running       = 1'b1;
					nxt.held_setpoint = item.setpoint_tenths;
					nxt.deadline_ms   = item.now_ms + span_ms;
					step.left_ms      = span_ms;
					not_reached       = neg_span[31];
				end
			end
			KIND_CANCEL: begin
				nxt = '0;
			end
			KIND_TICK: begin
				if (reached) begin
					nxt = '0;
				end
			end
			default: begin
				nxt = cur;
			end
		endcase
		step.counting = nxt.running & not_reached;
	end

endmodule

// ----- rtl/bdt_secs.sv -----
// Milliseconds left to whole seconds, rounded up and saturated.
module bdt_secs (
	input  logic                      counting,
	input  logic [31:0]               left_ms,
	output logic [bdt_pkg::REM_W-1:0] remaining
);
	import bdt_pkg::*;

	localparam int PROD_W = SECS_IN_W + RECIP_W;

	logic                 saturate;
	logic [SECS_IN_W-1:0] ceil_ms;
	logic [PROD_W-1:0]    prod;

	assign saturate = 64'(left_ms) > REM_SAT_MS;
	assign ceil_ms  = left_ms[SECS_IN_W-1:0] + SECS_IN_W'(ROUND_UP_MS);
	assign prod     = PROD_W'(ceil_ms) * PROD_W'(RECIP_MUL);

	always_comb begin
		if (!counting) begin
			remaining = '0;
		end else if (saturate) begin
			remaining = REM_MAX;
		end else begin
			remaining = prod[RECIP_SHIFT +: REM_W];
		end
	end

endmodule

// ----- rtl/boost_deadline_timer.sv -----
// Top level of the timed heating boost with wrap-safe deadline.
//
//  channel | handshake             | payload
//  --------+-----------------------+---------------------------------------------
//  in      | in_valid / in_ready   | kind, now_ms, setpoint_tenths, duration_min,
//          |                       | remote_owned, season_on
//  out     | out_valid / out_ready | status, is_active, active_setpoint, remaining_s
//  cfg     | cfg_valid / cfg_ready | cfg_index, cfg_data (always ready)
//
// One transaction per cycle sustained while out_ready holds; each transaction
// passes the input register, state update and seconds conversion in turn.
// The boost state is updated as a transaction leaves the input register, so the
// next one sees it at once. A stalled output backs up stage by stage; in_ready
// drops only when all three stages hold data. Reset clears the boost and loads
// the default flow bounds.
module boost_deadline_timer (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [1:0]                kind,
	input  logic [31:0]               now_ms,
	input  logic signed [15:0]        setpoint_tenths,
	input  logic [15:0]               duration_min,
	input  logic                      remote_owned,
	input  logic                      season_on,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [2:0]                status,
	output logic                      is_active,
	output logic signed [15:0]        active_setpoint,
	output logic [bdt_pkg::REM_W-1:0] remaining_s,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic                      cfg_index,
	input  logic signed [15:0]        cfg_data
);
	import bdt_pkg::*;

	logic               cfg_min_sel;
	logic signed [15:0] flow_min_tenths_q;
	logic signed [15:0] flow_max_tenths_q;
	boost_t             boost_q;
	boost_t             boost_nxt;
	step_t              step_nxt;

	item_t              item_s1;
	logic               valid_s1;
	step_t              step_s2;
	logic               active_s2;
	logic signed [15:0] setpoint_s2;
	logic               valid_s2;
	logic [REM_W-1:0]   remaining_nxt;
	status_t            status_s3;
	logic               active_s3;
	logic signed [15:0] setpoint_s3;
	logic [REM_W-1:0]   remaining_s3;
	logic               valid_s3;

	logic en_s1;
	logic en_s2;
	logic en_s3;

	assign en_s3    = ~valid_s3 | out_ready;
	assign en_s2    = ~valid_s2 | en_s3;
	assign en_s1    = ~valid_s1 | en_s2;
	assign in_ready = en_s1;

	assign cfg_ready   = 1'b1;
	assign cfg_min_sel = (cfg_idx_t'(cfg_index) == CFG_FLOW_MIN);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flow_min_tenths_q <= FLOW_MIN_RST;
			flow_max_tenths_q <= FLOW_MAX_RST;
		end else if (cfg_valid) begin
			if (cfg_min_sel) begin
				flow_min_tenths_q <= cfg_data;
			end else begin
				flow_max_tenths_q <= cfg_data;
			end
		end
	end

	bdt_eval u_eval (
		.item     (item_s1),
		.cur      (boost_q),
		.flow_min (flow_min_tenths_q),
		.flow_max (flow_max_tenths_q),
		.nxt      (boost_nxt),
		.step     (step_nxt)
	);

	bdt_secs u_secs (
		.counting  (step_s2.counting),
		.left_ms   (step_s2.left_ms),
		.remaining (remaining_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			boost_q  <= '0;
		end else begin
			if (en_s1) begin
				valid_s1 <= in_valid;
			end
			if (en_s2) begin
				valid_s2 <= valid_s1;
				if (valid_s1) begin
					boost_q <= boost_nxt;
				end
			end
			if (en_s3) begin
				valid_s3 <= valid_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1 && in_valid) begin
			item_s1 <= '{
				kind:            kind_t'(kind),
				now_ms:          now_ms,
				setpoint_tenths: setpoint_tenths,
				duration_min:    duration_min,
				remote_owned:    remote_owned,
				season_on:       season_on
			};
		end
		if (en_s2 && valid_s1) begin
			step_s2     <= step_nxt;
			active_s2   <= boost_nxt.running;
			setpoint_s2 <= boost_nxt.held_setpoint;
		end
		if (en_s3 && valid_s2) begin
			status_s3    <= step_s2.status;
			active_s3    <= active_s2;
			setpoint_s3  <= setpoint_s2;
			remaining_s3 <= remaining_nxt;
		end
	end

	assign out_valid       = valid_s3;
	assign status          = status_s3;
	assign is_active       = active_s3;
	assign active_setpoint = setpoint_s3;
	assign remaining_s     = remaining_s3;

endmodule

// ----- rtl/bdt_checker.sv -----
// Port-level checks of the boost deadline timer, bound to the top level.
module bdt_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      in_ready,
	input logic                      out_valid,
	input logic                      out_ready,
	input logic [2:0]                status,
	input logic                      is_active,
	input logic signed [15:0]        active_setpoint,
	input logic [bdt_pkg::REM_W-1:0] remaining_s
);
	import bdt_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) &&
		$stable(is_active) && $stable(active_setpoint) && $stable(remaining_s))
		else $error("result changed while stalled");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status == ST_OK || status == ST_REMOTE ||
		status == ST_SEASON || status == ST_MINUTES || status == ST_RANGE)
		else $error("status code out of range");

	a_idle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !is_active |-> active_setpoint == 16'sd0 && remaining_s == '0)
		else $error("inactive boost reports setpoint or time");

	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty output");

endmodule

bind boost_deadline_timer bdt_checker u_bdt_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.in_ready        (in_ready),
	.out_valid       (out_valid),
	.out_ready       (out_ready),
	.status          (status),
	.is_active       (is_active),
	.active_setpoint (active_setpoint),
	.remaining_s     (remaining_s)
);
